### hdl/gpc_pkg.sv
// ----------------------------------------------------------------------------
// gpc_pkg
// Shared types and constants of the GPIO port interrupt controller: register
// map, mode codes, port-state field layout and the per-item command.
// ----------------------------------------------------------------------------
package gpc_pkg;

  localparam int DATA_W = 32;

  // Bus beat kinds
  localparam logic [1:0] MODE_READ   = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;

  // Register bases; a port's register sits at base | (port << 4)
  localparam logic [13:0] BASE_MASK  = 14'h3E00;
  localparam logic [13:0] BASE_DIR   = 14'h2000;
  localparam logic [13:0] BASE_DIN   = 14'h2200;
  localparam logic [13:0] BASE_DOUT  = 14'h2400;
  localparam logic [13:0] BASE_IEN   = 14'h2600;
  localparam logic [13:0] BASE_IMSK  = 14'h2800;
  localparam logic [13:0] BASE_ITYP  = 14'h2a00;
  localparam logic [13:0] BASE_IPOL  = 14'h2c00;
  localparam logic [13:0] BASE_IBOTH = 14'h2e00;
  localparam logic [13:0] BASE_STAT  = 14'h3000;
  localparam logic [13:0] BASE_RAW   = 14'h3200;
  localparam logic [13:0] BASE_ECLR  = 14'h3400;
  localparam logic [13:0] BASE_DEB   = 14'h3800;

  // Fields of one port-state entry
  localparam int NUM_FIELDS = 10;
  typedef enum logic [3:0] {
    F_DIR, F_DOUT, F_IEN, F_IMSK, F_ITYP, F_IPOL, F_IBOTH, F_DEB, F_PIN, F_LATCH
  } field_t;

  typedef enum logic [2:0] {
    K_NONE, K_RW, K_DIN, K_STAT, K_RAW, K_ECLR
  } addr_kind_t;

  // rd/wr/smp are only set when the addressed port exists
  typedef struct packed {
    logic       rd;
    logic       wr;
    logic       smp;
    addr_kind_t kind;
    field_t     fld;
  } gpc_cmd_t;

endpackage

### hdl/gpc_port_ram.sv
// ----------------------------------------------------------------------------
// gpc_port_ram
// Port-state memory: one entry per port, one write and one registered read
// per cycle. Entries read as zero until first written after reset.
// ----------------------------------------------------------------------------
module gpc_port_ram #(
  parameter int DEPTH = 6,
  parameter int AW    = 3,
  parameter int WIDTH = 320
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic             rd_in_range;

  assign rd_in_range = {1'b0, rd_addr} < (AW+1)'(DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // read-first: a same-cycle write to the read address returns the old entry
  always_ff @(posedge clk) begin
    if (rd_in_range && vld[rd_addr]) begin
      rd_data <= mem[rd_addr];
    end else begin
      rd_data <= '0;
    end
  end

endmodule

### hdl/gpc_update.sv
// ----------------------------------------------------------------------------
// gpc_update
// Modify step for one port entry: register read data, register write or
// edge clear, pin sample with edge capture, and the port's interrupt line.
// ----------------------------------------------------------------------------
module gpc_update import gpc_pkg::*; #(
  parameter int PORT_WIDTH = 32
) (
  input  gpc_cmd_t                          cmd,
  input  logic [NUM_FIELDS*PORT_WIDTH-1:0]  cur,
  input  logic [PORT_WIDTH-1:0]             data,
  output logic [NUM_FIELDS*PORT_WIDTH-1:0]  nxt,
  output logic [PORT_WIDTH-1:0]             rd_val,
  output logic                              irq
);

  logic [NUM_FIELDS-1:0][PORT_WIDTH-1:0] e;
  logic [NUM_FIELDS-1:0][PORT_WIDTH-1:0] n;
  logic [PORT_WIDTH-1:0] sens_o, raw_o, sens_n, raw_n;
  logic [PORT_WIDTH-1:0] rise, fall, single, hit;

  assign e   = cur;
  assign nxt = n;

  always_comb begin
    // status from the current entry
    sens_o = e[F_ITYP] | e[F_IBOTH];
    raw_o  = e[F_IEN] & ((sens_o & e[F_LATCH]) | (~sens_o & ~(e[F_PIN] ^ e[F_IPOL])));

    rd_val = '0;
    if (cmd.rd) begin
      case (cmd.kind)
        K_RW:    rd_val = e[cmd.fld];
        K_DIN:   rd_val = e[F_PIN];
        K_STAT:  rd_val = raw_o & ~e[F_IMSK];
        K_RAW:   rd_val = raw_o;
        default: rd_val = '0;
      endcase
    end

    rise   = data & ~e[F_PIN];
    fall   = ~data & e[F_PIN];
    single = (rise & e[F_IPOL]) | (fall & ~e[F_IPOL]);
    hit    = ((e[F_IBOTH] & (rise | fall)) | (~e[F_IBOTH] & single))
             & sens_o & e[F_IEN];

    n = e;
    if (cmd.wr) begin
      case (cmd.kind)
        K_RW:    n[cmd.fld] = data;
        K_ECLR:  n[F_LATCH] = e[F_LATCH] & ~data;
        default: n = e;
      endcase
    end else if (cmd.smp) begin
      n[F_LATCH] = e[F_LATCH] | hit;
      n[F_PIN]   = data;
    end

    sens_n = n[F_ITYP] | n[F_IBOTH];
    raw_n  = n[F_IEN] & ((sens_n & n[F_LATCH]) | (~sens_n & ~(n[F_PIN] ^ n[F_IPOL])));
    irq    = |(raw_n & ~n[F_IMSK]);
  end

endmodule

### hdl/gpio_port_interrupt_controller.sv
// ----------------------------------------------------------------------------
// gpio_port_interrupt_controller
// Multi-port GPIO register block with per-pin level or edge interrupts.
// ----------------------------------------------------------------------------
// Each input beat is a register read, a register write or a pin sample for
// one port; each gives one result beat with read data, the interrupt lines
// of all ports and the drive outputs of the port named by the port field,
// all reflecting state after the beat. Port state lives in a single-port-read
// RAM, one entry per port. The target entry is read as the item is accepted;
// in S_MOD it is modified and written back while the drive port's entry is
// read, and in S_DRV the result is loaded once the output can take it. A new
// item is taken only in S_IDLE, after the last result has been loaded, as
// the single RAM read port serves both entry reads.
// After reset all registers read zero; there is no clearing pass.
// ----------------------------------------------------------------------------
module gpio_port_interrupt_controller import gpc_pkg::*; #(
  parameter int NUM_PORTS  = 6,
  parameter int PORT_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        mode,
  input  logic [13:0]       address,
  input  logic [2:0]        port,
  input  logic [DATA_W-1:0] wdata,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] rdata,
  output logic [5:0]        irq_lines,
  output logic [DATA_W-1:0] drive_level,
  output logic [DATA_W-1:0] drive_enable
);

  localparam int AW      = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int ENTRY_W = NUM_FIELDS * PORT_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MOD  = 3'b010,
    S_DRV  = 3'b100
  } state_t;

  state_t state, state_next;

  gpc_cmd_t               cmd_d, cmd_q;
  addr_kind_t             kind_d;
  field_t                 fld_d;
  logic                   addr_ok, sel_ok;
  logic [AW-1:0]          tgt_d, tgt_q, sel_q;
  logic                   sel_ok_q;
  logic [PORT_WIDTH-1:0]  data_q;

  logic [AW-1:0]          ram_rd_addr;
  logic [ENTRY_W-1:0]     ram_rd;
  logic                   ram_we;
  logic [ENTRY_W-1:0]     upd_nxt;
  logic [PORT_WIDTH-1:0]  upd_rd;
  logic                   upd_irq;

  logic [NUM_FIELDS-1:0][PORT_WIDTH-1:0] ram_fields, nxt_fields;
  logic                   fwd;
  logic [PORT_WIDTH-1:0]  fwd_dout, fwd_dir, rd_hold;
  logic [NUM_PORTS-1:0]   irq_q;
  logic [5:0]             irq_view;
  logic [PORT_WIDTH-1:0]  drv_dout, drv_dir;
  logic                   in_fire, load_out;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // address decode
  always_comb begin
    kind_d = K_NONE;
    fld_d  = F_DIR;
    case (address & BASE_MASK)
      BASE_DIR:   begin kind_d = K_RW; fld_d = F_DIR;   end
      BASE_DOUT:  begin kind_d = K_RW; fld_d = F_DOUT;  end
      BASE_IEN:   begin kind_d = K_RW; fld_d = F_IEN;   end
      BASE_IMSK:  begin kind_d = K_RW; fld_d = F_IMSK;  end
      BASE_ITYP:  begin kind_d = K_RW; fld_d = F_ITYP;  end
      BASE_IPOL:  begin kind_d = K_RW; fld_d = F_IPOL;  end
      BASE_IBOTH: begin kind_d = K_RW; fld_d = F_IBOTH; end
      BASE_DEB:   begin kind_d = K_RW; fld_d = F_DEB;   end
      BASE_DIN:   kind_d = K_DIN;
      BASE_STAT:  kind_d = K_STAT;
      BASE_RAW:   kind_d = K_RAW;
      BASE_ECLR:  kind_d = K_ECLR;
      default:    kind_d = K_NONE;
    endcase

    addr_ok = address[13] && (address[3:0] == 4'd0) && (address[8:4] < 5'(NUM_PORTS));
    sel_ok  = {1'b0, port} < 4'(NUM_PORTS);

    cmd_d.rd   = (mode == MODE_READ) && addr_ok;
    cmd_d.wr   = (mode == MODE_WRITE) && addr_ok;
    cmd_d.smp  = (mode == MODE_SAMPLE) && sel_ok;
    cmd_d.kind = kind_d;
    cmd_d.fld  = fld_d;

    tgt_d = cmd_d.smp ? port[AW-1:0] : address[4 +: AW];
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tgt_q    <= tgt_d;
      sel_q    <= port[AW-1:0];
      sel_ok_q <= sel_ok;
      data_q   <= wdata[PORT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q <= '0;
    end else if (in_fire) begin
      cmd_q <= cmd_d;
    end
  end

  // target entry first, then the drive port's entry
  assign ram_rd_addr = (state == S_IDLE) ? tgt_d : sel_q;
  assign ram_we      = (state == S_MOD) && (cmd_q.wr || cmd_q.smp);

  gpc_port_ram #(
    .DEPTH (NUM_PORTS),
    .AW    (AW),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (ram_we),
    .wr_addr (tgt_q),
    .wr_data (upd_nxt),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd)
  );

  gpc_update #(
    .PORT_WIDTH (PORT_WIDTH)
  ) u_update (
    .cmd    (cmd_q),
    .cur    (ram_rd),
    .data   (data_q),
    .nxt    (upd_nxt),
    .rd_val (upd_rd),
    .irq    (upd_irq)
  );

  assign ram_fields = ram_rd;
  assign nxt_fields = upd_nxt;

  // forward the written entry when the drive port is the one just updated
  always_ff @(posedge clk) begin
    if (state == S_MOD) begin
      fwd      <= ram_we && (sel_q == tgt_q);
      fwd_dout <= nxt_fields[F_DOUT];
      fwd_dir  <= nxt_fields[F_DIR];
      rd_hold  <= upd_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_q <= '0;
    end else if (ram_we) begin
      irq_q[tgt_q] <= upd_irq;
    end
  end

  for (genvar i = 0; i < 6; i++) begin : g_irq
    if (i < NUM_PORTS) begin : g_on
      assign irq_view[i] = irq_q[i];
    end else begin : g_off
      assign irq_view[i] = 1'b0;
    end
  end

  always_comb begin
    drv_dout = '0;
    drv_dir  = '0;
    if (sel_ok_q) begin
      drv_dout = fwd ? fwd_dout : ram_fields[F_DOUT];
      drv_dir  = fwd ? fwd_dir  : ram_fields[F_DIR];
    end
  end

  assign load_out = (state == S_DRV) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_fire) state_next = S_MOD;
      S_MOD:   state_next = S_DRV;
      S_DRV:   if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rdata        <= DATA_W'(rd_hold);
      irq_lines    <= irq_view;
      drive_level  <= DATA_W'(drv_dout);
      drive_enable <= DATA_W'(drv_dir);
    end
  end

endmodule
